@@ rtl/tnf_pkg.sv @@
// Shared types and constants of the face-forward triangle normal block.
// No dependencies.
`default_nettype none
package tnf_pkg;
    localparam int MAG_W       = 31;
    localparam int LEN_W       = 32;
    localparam int RCP_W       = 33;
    localparam int SUM_W       = 64;
    localparam int OUT_W       = 16;
    localparam int NORM_LEAD   = 30;
    localparam int RCP_SHIFT   = 62;
    localparam int ROUND_SHIFT = 47;
    localparam int PROD_W      = MAG_W + RCP_W;
    localparam logic [OUT_W+1:0] OUT_MAX = 18'd32767;

    typedef struct packed {
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic [MAG_W-1:0] mag_z;
        logic             neg_x;
        logic             neg_y;
        logic             neg_z;
        logic             degen;
    } tnf_norm_t;
endpackage
`default_nettype wire

@@ rtl/tnf_if.sv @@
// Valid/ready channels of the face-forward triangle normal block.
// Depends on nothing; hit field widths follow COORD_WIDTH, result normals are 16 bits.
`default_nettype none
interface tnf_hit_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_a_z;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_z;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_z;
    logic signed [COORD_WIDTH-1:0] ray_dir_x;
    logic signed [COORD_WIDTH-1:0] ray_dir_y;
    logic signed [COORD_WIDTH-1:0] ray_dir_z;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
               vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, ray_dir_x, ray_dir_y,
               ray_dir_z,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
               vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, ray_dir_x, ray_dir_y,
               ray_dir_z,
        output ready
    );
endinterface

interface tnf_normal_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/tnf_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on tnf_pkg.
`default_nettype none
module tnf_sqrt_pipe #(
    parameter int PAY_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tnf_pkg::SUM_W-1:0]   radicand,
    input  logic [PAY_W-1:0]            in_pay,
    output logic                        out_valid,
    output logic [tnf_pkg::LEN_W-1:0]   root,
    output logic [PAY_W-1:0]            out_pay
);
    import tnf_pkg::*;

    localparam int STEPS = LEN_W;

    logic [SUM_W:0]   rem_s  [STEPS+1];
    logic [LEN_W-1:0] root_s [STEPS+1];
    logic [PAY_W-1:0] pay_s  [STEPS+1];
    logic             vld_s  [STEPS+1];

    assign rem_s[0]  = (SUM_W+1)'(radicand);
    assign root_s[0] = '0;
    assign pay_s[0]  = in_pay;
    assign vld_s[0]  = in_valid;

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int K = STEPS - 1 - j;
        logic [SUM_W:0]   trial;
        logic [SUM_W:0]   rem_next;
        logic [SUM_W:0]   rem_reg;
        logic [LEN_W-1:0] root_next;
        logic [LEN_W-1:0] root_reg;
        logic [PAY_W-1:0] pay_reg;
        logic             vld_reg;

        always_comb
        begin
            trial     = ((SUM_W+1)'(root_s[j]) << (K + 1)) | ((SUM_W+1)'(1) << (2 * K));
            rem_next  = rem_s[j];
            root_next = root_s[j];
            if (rem_s[j] >= trial)
            begin
                rem_next  = rem_s[j] - trial;
                root_next = root_s[j] | (LEN_W'(1) << K);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_s[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                pay_reg  <= pay_s[j];
            end
        end

        assign rem_s[j+1]  = rem_reg;
        assign root_s[j+1] = root_reg;
        assign pay_s[j+1]  = pay_reg;
        assign vld_s[j+1]  = vld_reg;
    end

    assign out_valid = vld_s[STEPS];
    assign root      = root_s[STEPS];
    assign out_pay   = pay_s[STEPS];
endmodule
`default_nettype wire

@@ rtl/tnf_recip_pipe.sv @@
// Pipelined restoring divider for 2^62 / length, one quotient bit per stage.
// Depends on tnf_pkg.
`default_nettype none
module tnf_recip_pipe #(
    parameter int PAY_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tnf_pkg::LEN_W-1:0]   divisor,
    input  logic [PAY_W-1:0]            in_pay,
    output logic                        out_valid,
    output logic [tnf_pkg::RCP_W-1:0]   quotient,
    output logic [PAY_W-1:0]            out_pay
);
    import tnf_pkg::*;

    localparam int STEPS = RCP_W;

    logic [SUM_W:0]   rem_s [STEPS+1];
    logic [LEN_W-1:0] div_s [STEPS+1];
    logic [RCP_W-1:0] quo_s [STEPS+1];
    logic [PAY_W-1:0] pay_s [STEPS+1];
    logic             vld_s [STEPS+1];

    assign rem_s[0] = (SUM_W+1)'(1) << RCP_SHIFT;
    assign div_s[0] = divisor;
    assign quo_s[0] = '0;
    assign pay_s[0] = in_pay;
    assign vld_s[0] = in_valid;

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int K = STEPS - 1 - j;
        logic [SUM_W:0]   trial;
        logic [SUM_W:0]   rem_next;
        logic [SUM_W:0]   rem_reg;
        logic [RCP_W-1:0] quo_next;
        logic [RCP_W-1:0] quo_reg;
        logic [LEN_W-1:0] div_reg;
        logic [PAY_W-1:0] pay_reg;
        logic             vld_reg;

        always_comb
        begin
            trial    = (SUM_W+1)'(div_s[j]) << K;
            rem_next = rem_s[j];
            quo_next = quo_s[j];
            if (rem_s[j] >= trial)
            begin
                rem_next = rem_s[j] - trial;
                quo_next = quo_s[j] | (RCP_W'(1) << K);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_s[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                div_reg <= div_s[j];
                pay_reg <= pay_s[j];
            end
        end

        assign rem_s[j+1] = rem_reg;
        assign div_s[j+1] = div_reg;
        assign quo_s[j+1] = quo_reg;
        assign pay_s[j+1] = pay_reg;
        assign vld_s[j+1] = vld_reg;
    end

    assign out_valid = vld_s[STEPS];
    assign quotient  = quo_s[STEPS];
    assign out_pay   = pay_s[STEPS];
endmodule
`default_nettype wire

@@ rtl/triangle_normal_facing.sv @@
// Face-forward unit normal of a hit triangle: top level and pipeline.
// Depends on tnf_pkg, tnf_if, tnf_sqrt_pipe and tnf_recip_pipe.
//
//   channel  dir  words
//   hit      in   three vertices and ray direction, COORD_WIDTH bits each
//   result   out  normal x/y/z in Q1.15 and degenerate flag
//
// One word enters per cycle unless the output stalls. The 7 front stages,
// 32 root stages, 33 reciprocal stages and 4 back stages all advance together;
// the root and divider stages resolve one bit each. A stalled output holds
// the whole pipeline and nothing is dropped. Reset clears valid bits only.
`default_nettype none
module triangle_normal_facing #(
    parameter int COORD_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tnf_hit_if.sink       hit,
    tnf_normal_if.source  result
);
    import tnf_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int EW    = W + 1;
    localparam int PPW   = 2 * W + 2;
    localparam int CW    = 2 * W + 3;
    localparam int LZ_W  = $clog2(CW);
    localparam int SH_W  = CW + NORM_LEAD;
    localparam int DPW   = OUT_W + W;
    localparam int DOTW  = OUT_W + W + 2;
    localparam int NRM_W = $bits(tnf_norm_t);
    localparam int PAY_W = NRM_W + 3 * W;

    function automatic logic [MAG_W-1:0] norm_shift(input logic [CW-1:0]   m,
                                                     input logic [LZ_W-1:0] lead);
        logic [SH_W-1:0] wide;
        begin
            wide = SH_W'(m);
            if (lead >= LZ_W'(NORM_LEAD))
                wide = wide >> (lead - LZ_W'(NORM_LEAD));
            else
                wide = wide << (LZ_W'(NORM_LEAD) - lead);
            return wide[MAG_W-1:0];
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] round_sat(input logic [PROD_W-1:0] p,
                                                          input logic neg,
                                                          input logic degen);
        logic [PROD_W:0]    sum;
        logic [OUT_W+1:0]   q;
        logic [OUT_W-1:0]   mag;
        begin
            sum = (PROD_W+1)'(p) + ((PROD_W+1)'(1) << (ROUND_SHIFT - 1));
            q   = sum[ROUND_SHIFT +: OUT_W+2];
            mag = (q > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : q[OUT_W-1:0];
            if (degen)
                return '0;
            return neg ? -$signed(mag) : $signed(mag);
        end
    endfunction

    logic en;
    logic vout_reg;

    assign en        = !vout_reg || result.ready;
    assign hit.ready = en;

    // stage 1: edges
    logic                 v1_reg;
    logic signed [EW-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [W-1:0]  d1x_reg, d1y_reg, d1z_reg;

    // stage 2: products
    logic                  v2_reg;
    logic signed [PPW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [W-1:0]   d2x_reg, d2y_reg, d2z_reg;

    // stage 3: cross product magnitudes
    logic                 v3_reg;
    logic signed [CW-1:0] cx_next, cy_next, cz_next;
    logic [CW-1:0]        m3x_reg, m3y_reg, m3z_reg;
    logic                 n3x_reg, n3y_reg, n3z_reg, g3_reg;
    logic signed [W-1:0]  d3x_reg, d3y_reg, d3z_reg;

    // stage 4: leading one
    logic                 v4_reg;
    logic [CW-1:0]        or_v;
    logic [LZ_W-1:0]      lead_next, lead_reg;
    logic [CW-1:0]        m4x_reg, m4y_reg, m4z_reg;
    logic                 n4x_reg, n4y_reg, n4z_reg, g4_reg;
    logic signed [W-1:0]  d4x_reg, d4y_reg, d4z_reg;

    // stages 5..7: normalize, square, sum
    logic                  v5_reg, v6_reg, v7_reg;
    tnf_norm_t             n5_reg, n6_reg, n7_reg;
    logic [3*W-1:0]        d5_reg, d6_reg, d7_reg;
    logic [2*MAG_W-1:0]    sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0]      sum_reg;

    always_comb
    begin
        lead_next = '0;
        or_v      = m3x_reg | m3y_reg | m3z_reg;
        for (int i = 0; i < CW; i++)
            if (or_v[i])
                lead_next = LZ_W'(i);
        cx_next = CW'(pa_reg) - CW'(pb_reg);
        cy_next = CW'(pc_reg) - CW'(pd_reg);
        cz_next = CW'(pe_reg) - CW'(pf_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= hit.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1x_reg <= EW'(hit.vertex_b_x) - EW'(hit.vertex_a_x);
            e1y_reg <= EW'(hit.vertex_b_y) - EW'(hit.vertex_a_y);
            e1z_reg <= EW'(hit.vertex_b_z) - EW'(hit.vertex_a_z);
            e2x_reg <= EW'(hit.vertex_c_x) - EW'(hit.vertex_a_x);
            e2y_reg <= EW'(hit.vertex_c_y) - EW'(hit.vertex_a_y);
            e2z_reg <= EW'(hit.vertex_c_z) - EW'(hit.vertex_a_z);
            d1x_reg <= hit.ray_dir_x;
            d1y_reg <= hit.ray_dir_y;
            d1z_reg <= hit.ray_dir_z;

            pa_reg  <= e1y_reg * e2z_reg;
            pb_reg  <= e1z_reg * e2y_reg;
            pc_reg  <= e1z_reg * e2x_reg;
            pd_reg  <= e1x_reg * e2z_reg;
            pe_reg  <= e1x_reg * e2y_reg;
            pf_reg  <= e1y_reg * e2x_reg;
            d2x_reg <= d1x_reg;
            d2y_reg <= d1y_reg;
            d2z_reg <= d1z_reg;

            m3x_reg <= cx_next[CW-1] ? CW'(-cx_next) : CW'(cx_next);
            m3y_reg <= cy_next[CW-1] ? CW'(-cy_next) : CW'(cy_next);
            m3z_reg <= cz_next[CW-1] ? CW'(-cz_next) : CW'(cz_next);
            n3x_reg <= cx_next[CW-1];
            n3y_reg <= cy_next[CW-1];
            n3z_reg <= cz_next[CW-1];
            g3_reg  <= (cx_next == '0) && (cy_next == '0) && (cz_next == '0);
            d3x_reg <= d2x_reg;
            d3y_reg <= d2y_reg;
            d3z_reg <= d2z_reg;

            lead_reg <= lead_next;
            m4x_reg  <= m3x_reg;
            m4y_reg  <= m3y_reg;
            m4z_reg  <= m3z_reg;
            n4x_reg  <= n3x_reg;
            n4y_reg  <= n3y_reg;
            n4z_reg  <= n3z_reg;
            g4_reg   <= g3_reg;
            d4x_reg  <= d3x_reg;
            d4y_reg  <= d3y_reg;
            d4z_reg  <= d3z_reg;

            n5_reg.mag_x <= norm_shift(m4x_reg, lead_reg);
            n5_reg.mag_y <= norm_shift(m4y_reg, lead_reg);
            n5_reg.mag_z <= norm_shift(m4z_reg, lead_reg);
            n5_reg.neg_x <= n4x_reg;
            n5_reg.neg_y <= n4y_reg;
            n5_reg.neg_z <= n4z_reg;
            n5_reg.degen <= g4_reg;
            d5_reg       <= {d4x_reg, d4y_reg, d4z_reg};

            sqx_reg <= n5_reg.mag_x * n5_reg.mag_x;
            sqy_reg <= n5_reg.mag_y * n5_reg.mag_y;
            sqz_reg <= n5_reg.mag_z * n5_reg.mag_z;
            n6_reg  <= n5_reg;
            d6_reg  <= d5_reg;

            sum_reg <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
            n7_reg  <= n6_reg;
            d7_reg  <= d6_reg;
        end
    end

    // length and reciprocal
    logic             vs_out, vr_out;
    logic [LEN_W-1:0] len;
    logic [RCP_W-1:0] rcp;
    logic [PAY_W-1:0] pay_s, pay_r;

    tnf_sqrt_pipe #(.PAY_W(PAY_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .radicand  (sum_reg),
        .in_pay    ({n7_reg, d7_reg}),
        .out_valid (vs_out),
        .root      (len),
        .out_pay   (pay_s)
    );

    tnf_recip_pipe #(.PAY_W(PAY_W)) u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vs_out),
        .divisor   (len),
        .in_pay    (pay_s),
        .out_valid (vr_out),
        .quotient  (rcp),
        .out_pay   (pay_r)
    );

    tnf_norm_t ns;
    tnf_norm_t nr;
    assign ns = pay_s[PAY_W-1 -: NRM_W];
    assign nr = pay_r[PAY_W-1 -: NRM_W];

    // stages 8..11: scale, round, facing test
    logic                    v8_reg, v9_reg, v10_reg;
    logic [PROD_W-1:0]       qx_reg, qy_reg, qz_reg;
    logic                    n8x_reg, n8y_reg, n8z_reg, g8_reg, g9_reg, g10_reg;
    logic [3*W-1:0]          d8_reg, d9_reg;
    logic signed [OUT_W-1:0] r9x_reg, r9y_reg, r9z_reg, r10x_reg, r10y_reg, r10z_reg;
    logic signed [DPW-1:0]   dpx_reg, dpy_reg, dpz_reg;
    logic signed [DOTW-1:0]  dot_next;
    logic signed [OUT_W-1:0] ox_reg, oy_reg, oz_reg;
    logic                    og_reg;

    assign dot_next = DOTW'(dpx_reg) + DOTW'(dpy_reg) + DOTW'(dpz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            v8_reg   <= vr_out;
            v9_reg   <= v8_reg;
            v10_reg  <= v9_reg;
            vout_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg  <= nr.mag_x * rcp;
            qy_reg  <= nr.mag_y * rcp;
            qz_reg  <= nr.mag_z * rcp;
            n8x_reg <= nr.neg_x;
            n8y_reg <= nr.neg_y;
            n8z_reg <= nr.neg_z;
            g8_reg  <= nr.degen;
            d8_reg  <= pay_r[3*W-1:0];

            r9x_reg <= round_sat(qx_reg, n8x_reg, g8_reg);
            r9y_reg <= round_sat(qy_reg, n8y_reg, g8_reg);
            r9z_reg <= round_sat(qz_reg, n8z_reg, g8_reg);
            g9_reg  <= g8_reg;
            d9_reg  <= d8_reg;

            dpx_reg  <= r9x_reg * $signed(d9_reg[3*W-1 -: W]);
            dpy_reg  <= r9y_reg * $signed(d9_reg[2*W-1 -: W]);
            dpz_reg  <= r9z_reg * $signed(d9_reg[W-1:0]);
            r10x_reg <= r9x_reg;
            r10y_reg <= r9y_reg;
            r10z_reg <= r9z_reg;
            g10_reg  <= g9_reg;

            ox_reg <= (dot_next > 0) ? -r10x_reg : r10x_reg;
            oy_reg <= (dot_next > 0) ? -r10y_reg : r10y_reg;
            oz_reg <= (dot_next > 0) ? -r10z_reg : r10z_reg;
            og_reg <= g10_reg;
        end
    end

    assign result.valid      = vout_reg;
    assign result.normal_x   = ox_reg;
    assign result.normal_y   = oy_reg;
    assign result.normal_z   = oz_reg;
    assign result.degenerate = og_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        vout_reg && og_reg |-> ox_reg == '0 && oy_reg == '0 && oz_reg == '0)
        else $error("degenerate word carries a nonzero normal");

    a_no_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        vout_reg |-> ox_reg != 16'sh8000 && oy_reg != 16'sh8000 && oz_reg != 16'sh8000)
        else $error("normal component out of Q1.15 range");

    a_norm_lead: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg && !n5_reg.degen |->
            |((n5_reg.mag_x | n5_reg.mag_y | n5_reg.mag_z) & (MAG_W'(1) << NORM_LEAD)))
        else $error("normalized magnitudes lack leading one");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        vs_out && !ns.degen |-> len[LEN_W-1 -: 2] != 2'b00)
        else $error("length below normalized range");
endmodule
`default_nettype wire
